[sv/cfr_pkg.sv]
// Shared types and constants for the CRC-checked frame receiver.
// Depends on nothing; used by cfr_check and crc_checked_frame_receiver.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  localparam int unsigned FRAME_BYTES = 24;
  // bytes covered by the CRC (0..21), CRC itself in 22..23
  localparam int unsigned CRC_SPAN    = 22;
  // stored body: bytes 2..22; byte 23 is taken straight from the wire
  localparam int unsigned BODY_BYTES  = FRAME_BYTES - 2;
  localparam int unsigned STORE_BYTES = BODY_BYTES - 1;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  CONF_MAX    = 8'd100;
  localparam logic [15:0] SEQ_RST     = 16'hFFFF;
  localparam logic [15:0] ANGLE_NONE  = 16'h8000;
  localparam logic [15:0] WIDTH_NONE  = 16'hFFFF;

  localparam int unsigned OUT_TDATA_W = 152;

  // register indexes on the configuration port
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_VERSION       = 2'd2;
  localparam logic [1:0] REG_MSG_TYPE      = 2'd3;

  // input word kinds carried on s_axis_tuser
  localparam logic CMD_RX_BYTE    = 1'b0;
  localparam logic CMD_LINK_RESET = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_CRC_ERR   = 3'd1,
    ST_VERSION   = 3'd2,
    ST_MSG_TYPE  = 3'd3,
    ST_CONF_RNG  = 3'd4,
    ST_DUPLICATE = 3'd5,
    ST_SYNC_LOSS = 3'd6
  } status_e;

  // body[k] holds frame byte k+2
  typedef logic [BODY_BYTES-1:0][7:0] body_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] sequence_res;
    logic [31:0] sender_time_ms;
    logic [7:0]  mode;
    logic [7:0]  status_flags;
    logic [15:0] lateral_error;
    logic [15:0] heading_error;
    logic [15:0] road_width;
    logic [15:0] junction_info;
    logic [7:0]  confidence;
    logic [7:0]  anomaly_flags;
    logic        vision_valid;
  } result_t;

endpackage

`default_nettype wire

[sv/cfr_check.sv]
// Frame check and field decode for one finished 24-byte frame.
// Depends on cfr_pkg. Purely combinational; the caller registers the result.
`timescale 1ns / 1ps
`default_nettype none

module cfr_check (
  input  var cfr_pkg::body_t   body_i,
  input  wire logic [15:0]     crc_i,
  input  wire logic [7:0]      exp_version_i,
  input  wire logic [7:0]      exp_msg_type_i,
  input  wire logic [15:0]     last_seq_i,
  input  wire logic            seq_seen_i,
  output cfr_pkg::result_t     res_o
);

  // byte n of the frame sits at body index n-2
  logic [15:0] seq;
  logic [15:0] lat;
  logic [15:0] head;
  logic [15:0] rw;
  logic [15:0] crc_rx;
  logic [7:0]  flags;

  assign seq    = {body_i[3],  body_i[2]};
  assign lat    = {body_i[11], body_i[10]};
  assign head   = {body_i[13], body_i[12]};
  assign rw     = {body_i[15], body_i[14]};
  assign crc_rx = {body_i[21], body_i[20]};
  assign flags  = body_i[9];

  always_comb begin
    res_o = '0;
    if (crc_rx != crc_i) begin
      res_o.status = cfr_pkg::ST_CRC_ERR;
    end else if (body_i[0] != exp_version_i) begin
      res_o.status = cfr_pkg::ST_VERSION;
    end else if (body_i[1] != exp_msg_type_i) begin
      res_o.status = cfr_pkg::ST_MSG_TYPE;
    end else if (body_i[18] > cfr_pkg::CONF_MAX) begin
      res_o.status = cfr_pkg::ST_CONF_RNG;
    end else if (seq_seen_i && (seq == last_seq_i)) begin
      res_o.status = cfr_pkg::ST_DUPLICATE;
    end else begin
      res_o.status = cfr_pkg::ST_ACCEPTED;
    end
    res_o.sequence_res   = seq;
    res_o.sender_time_ms = {body_i[7], body_i[6], body_i[5], body_i[4]};
    res_o.mode           = body_i[8];
    res_o.status_flags   = flags;
    res_o.lateral_error  = lat;
    res_o.heading_error  = head;
    res_o.road_width     = rw;
    res_o.junction_info  = {body_i[16], body_i[17]};
    res_o.confidence     = body_i[18];
    res_o.anomaly_flags  = body_i[19];
    res_o.vision_valid   = flags[0] && (lat != cfr_pkg::ANGLE_NONE)
                           && (head != cfr_pkg::ANGLE_NONE) && (rw != cfr_pkg::WIDTH_NONE);
  end

endmodule

`default_nettype wire

[sv/crc_checked_frame_receiver.sv]
// Serial frame receiver: header hunt, 24-byte collect, CRC-16/CCITT-FALSE and field checks.
// Depends on cfr_pkg and cfr_check.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_axis  | in  | rx_byte[7:0]                                    | cmd
//  m_axis  | out | sequence_res, sender_time_ms, mode, status_flags,| status[2:0]
//          |     | lateral_error, heading_error, road_width,       |
//          |     | junction_info, confidence, anomaly_flags,       |
//          |     | vision_valid, 7 zero bits                       |
//  cfg     | in  | cfg_we_i / cfg_idx_i / cfg_wdata_i, no read-back |
//
// One word accepted per cycle while s_axis_tready is high; a result is registered for m_axis.
// The per-byte CRC update (8 shift steps) sets the clock path.
// An output register plus a skid register let a word in while a result is stalled;
// s_axis_tready drops only when both hold a result.
// Reset: sync lost, sequence memory cleared, header 0xAA 0x55, version and type 1.
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_frame_receiver (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,  // rx_byte
  input  wire logic                             s_axis_tuser,  // cmd

  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [cfr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // see table above
  output      logic [2:0]                       m_axis_tuser,  // status

  input  wire logic                             cfg_we_i,
  input  wire logic [1:0]                       cfg_idx_i,
  input  wire logic [7:0]                       cfg_wdata_i
);

  localparam logic [1:0] PH_WAIT1   = 2'd0;
  localparam logic [1:0] PH_WAIT2   = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  localparam logic [4:0] CNT_FIRST = 5'd2;
  localparam logic [4:0] CNT_LAST  = 5'(cfr_pkg::FRAME_BYTES - 1);
  localparam logic [4:0] CNT_FULL  = 5'(cfr_pkg::FRAME_BYTES);
  localparam logic [4:0] CNT_CRC   = 5'(cfr_pkg::CRC_SPAN);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ cfr_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // configuration
  logic [7:0] hdr1_q, hdr2_q, ver_q, type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q <= 8'hAA;
      hdr2_q <= 8'h55;
      ver_q  <= 8'h01;
      type_q <= 8'h01;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfr_pkg::REG_HEADER_FIRST:  hdr1_q <= cfg_wdata_i;
        cfr_pkg::REG_HEADER_SECOND: hdr2_q <= cfg_wdata_i;
        cfr_pkg::REG_VERSION:       ver_q  <= cfg_wdata_i;
        cfr_pkg::REG_MSG_TYPE:      type_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // receive state
  logic [1:0]  phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] lseq_q, lseq_d;
  logic        seen_q, seen_d;
  logic [7:0]  store_q [cfr_pkg::STORE_BYTES];

  logic              accept;
  logic [7:0]        rx_b;
  logic [15:0]       crc_src;
  logic [15:0]       crc_next;
  logic              wr_en;
  logic [4:0]        wr_idx;
  cfr_pkg::body_t    body;
  cfr_pkg::result_t  chk_res;
  cfr_pkg::result_t  r;
  logic              r_valid;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign rx_b   = s_axis_tdata;
  assign wr_idx = cnt_q - CNT_FIRST;

  // a fresh hunt restarts the CRC, otherwise it runs on
  assign crc_src  = ((phase_q == PH_WAIT1) || ((phase_q == PH_WAIT2) && (rx_b != hdr2_q)))
                    ? cfr_pkg::CRC_INIT : crc_q;
  assign crc_next = crc_byte(crc_src, rx_b);

  always_comb begin
    for (int k = 0; k < int'(cfr_pkg::STORE_BYTES); k++) begin
      body[k] = store_q[k];
    end
    body[cfr_pkg::BODY_BYTES-1] = rx_b;
  end

  cfr_check u_check (
    .body_i         (body),
    .crc_i          (crc_q),
    .exp_version_i  (ver_q),
    .exp_msg_type_i (type_q),
    .last_seq_i     (lseq_q),
    .seq_seen_i     (seen_q),
    .res_o          (chk_res)
  );

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    lseq_d  = lseq_q;
    seen_d  = seen_q;
    wr_en   = 1'b0;
    r_valid = 1'b0;
    r       = '0;
    r.status = cfr_pkg::ST_SYNC_LOSS;
    if (accept) begin
      if (s_axis_tuser == cfr_pkg::CMD_LINK_RESET) begin
        // link reset
        phase_d = PH_WAIT1;
        cnt_d   = '0;
        crc_d   = cfr_pkg::CRC_INIT;
        lseq_d  = cfr_pkg::SEQ_RST;
        seen_d  = 1'b0;
      end else begin
        unique case (phase_q)
          PH_WAIT1: begin
            if (rx_b == hdr1_q) begin
              crc_d   = crc_next;
              phase_d = PH_WAIT2;
            end else begin
              r_valid = 1'b1;
            end
          end
          PH_WAIT2: begin
            if (rx_b == hdr2_q) begin
              crc_d   = crc_next;
              cnt_d   = CNT_FIRST;
              phase_d = PH_COLLECT;
            end else if (rx_b == hdr1_q) begin
              crc_d = crc_next;
            end else begin
              phase_d = PH_WAIT1;
              r_valid = 1'b1;
            end
          end
          PH_COLLECT: begin
            if (cnt_q < CNT_FULL) begin
              if (cnt_q < CNT_CRC) begin
                crc_d = crc_next;
              end
              if (cnt_q == CNT_LAST) begin
                phase_d = PH_WAIT1;
                cnt_d   = '0;
                r_valid = 1'b1;
                r       = chk_res;
                if (chk_res.status == cfr_pkg::ST_ACCEPTED) begin
                  lseq_d = chk_res.sequence_res;
                  seen_d = 1'b1;
                end
              end else begin
                wr_en = 1'b1;
                cnt_d = cnt_q + 5'd1;
              end
            end else begin
              phase_d = PH_WAIT1;
              cnt_d   = '0;
            end
          end
          default: begin
            phase_d = PH_WAIT1;
            cnt_d   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT1;
      cnt_q   <= '0;
      crc_q   <= cfr_pkg::CRC_INIT;
      lseq_q  <= cfr_pkg::SEQ_RST;
      seen_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      lseq_q  <= lseq_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= rx_b;
    end
  end

  // output register and skid register
  logic              o_valid_q, sk_valid_q;
  cfr_pkg::result_t  o_q, sk_q;
  logic              o_stall;

  assign o_stall       = o_valid_q && !m_axis_tready;
  assign s_axis_tready = !sk_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q  <= 1'b0;
      sk_valid_q <= 1'b0;
    end else if (o_stall) begin
      if (r_valid) begin
        sk_valid_q <= 1'b1;
      end
    end else if (sk_valid_q) begin
      o_valid_q  <= 1'b1;
      sk_valid_q <= r_valid;
    end else begin
      o_valid_q <= r_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_stall) begin
      if (r_valid) begin
        sk_q <= r;
      end
    end else if (sk_valid_q) begin
      o_q <= sk_q;
      if (r_valid) begin
        sk_q <= r;
      end
    end else if (r_valid) begin
      o_q <= r;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_q.status;
  assign m_axis_tdata  = {7'b0, o_q.vision_valid, o_q.anomaly_flags, o_q.confidence,
                          o_q.junction_info, o_q.road_width, o_q.heading_error,
                          o_q.lateral_error, o_q.status_flags, o_q.mode,
                          o_q.sender_time_ms, o_q.sequence_res};

  // checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> o_valid_q)
    else $error("skid holds a word while the output register is empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COLLECT) |-> ((cnt_q >= CNT_FIRST) && (cnt_q < CNT_FULL)))
    else $error("byte count out of range while collecting");

  a_sync_loss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == cfr_pkg::ST_SYNC_LOSS)) |-> (m_axis_tdata == '0))
    else $error("sync-loss result carries nonzero fields");

  a_link_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser == cfr_pkg::CMD_LINK_RESET))
      |=> ((phase_q == PH_WAIT1) && !seen_q && (crc_q == cfr_pkg::CRC_INIT)))
    else $error("link reset did not clear sync and sequence memory");

  a_no_frame_outside_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid && (r.status != cfr_pkg::ST_SYNC_LOSS)) |-> (phase_q == PH_COLLECT))
    else $error("frame status produced outside collect phase");

endmodule

`default_nettype wire
